@@ rtl/steering_angle_from_yaw_rate_filter_top_defines.svh @@
// ----------------------------------------------------------------------------
// steering angle filter: assertion macros
// shared helpers for the checker; clk and rst are taken from the using scope
// ----------------------------------------------------------------------------
`ifndef STEERING_ANGLE_FROM_YAW_RATE_FILTER_TOP_DEFINES_SVH
`define STEERING_ANGLE_FROM_YAW_RATE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, held off while in reset
`define SAFYR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("steering filter check failed");

// next-cycle implication, held off while in reset
`define SAFYR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("steering filter check failed");

`endif

@@ rtl/safyr_pkg.sv @@
// ----------------------------------------------------------------------------
// safyr_pkg
// widths, register map, reset values and constant tables of the steering
// angle filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package safyr_pkg;

  // default build parameters
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // arctangent table length and index width
  localparam int ATAN_LEN = 24;
  localparam int ATAN_IW  = 5;

  // field and register widths
  localparam int DATA_W      = 24;
  localparam int WHEELBASE_W = 22;
  localparam int THRESH_W    = 23;
  localparam int GAIN_W      = 17;
  localparam int ID_W        = 11;

  // apb port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // register reset values
  localparam logic [WHEELBASE_W-1:0] WHEELBASE_RST   = WHEELBASE_W'(29491);
  localparam logic [THRESH_W-1:0]    THRESH_RST      = THRESH_W'(3277);
  localparam logic [GAIN_W-1:0]      ANGLE_GAIN_RST  = GAIN_W'(5898);
  localparam logic [GAIN_W-1:0]      SPEED_GAIN_RST  = GAIN_W'(5243);
  localparam logic [ID_W-1:0]        SPEED_ID_RST    = ID_W'(11'h425);
  localparam logic [ID_W-1:0]        ANGLE_ID_RST    = ID_W'(11'h080);

  // frame kinds
  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_WHEELBASE  = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_ANGLE_GAIN = 3'd2,
    REG_SPEED_GAIN = 3'd3,
    REG_SPEED_ID   = 3'd4,
    REG_ANGLE_ID   = 3'd5
  } reg_idx_t;

  // saturation to the payload range
  localparam int SAT_W = 48;
  localparam logic signed [SAT_W-1:0] DATA_HI = SAT_W'((longint'(1) << (DATA_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] DATA_LO = -DATA_HI - SAT_W'(1);

  // atan(2^-i) in Q30
  function automatic logic signed [31:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic signed [31:0] r;
    unique case (idx)
      5'd0:    r = 32'sd843314857;
      5'd1:    r = 32'sd497837829;
      5'd2:    r = 32'sd263043837;
      5'd3:    r = 32'sd133525159;
      5'd4:    r = 32'sd67021687;
      5'd5:    r = 32'sd33543516;
      5'd6:    r = 32'sd16775851;
      5'd7:    r = 32'sd8388437;
      5'd8:    r = 32'sd4194283;
      5'd9:    r = 32'sd2097149;
      5'd10:   r = 32'sd1048576;
      5'd11:   r = 32'sd524288;
      5'd12:   r = 32'sd262144;
      5'd13:   r = 32'sd131072;
      5'd14:   r = 32'sd65536;
      5'd15:   r = 32'sd32768;
      5'd16:   r = 32'sd16384;
      5'd17:   r = 32'sd8192;
      5'd18:   r = 32'sd4096;
      5'd19:   r = 32'sd2048;
      5'd20:   r = 32'sd1024;
      5'd21:   r = 32'sd512;
      5'd22:   r = 32'sd256;
      5'd23:   r = 32'sd128;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // clamp a wide signed value into the payload range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] c;
    if (v > DATA_HI) begin
      c = DATA_HI;
    end else if (v < DATA_LO) begin
      c = DATA_LO;
    end else begin
      c = v;
    end
    return c[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/steering_angle_from_yaw_rate_filter_top.sv @@
// One word in (forward velocity, yaw rate) gives two words out: the smoothed
// velocity under speed_frame_id, then the smoothed steering angle under
// angle_frame_id, with last set on the second. The angle is atan(yaw *
// wheelbase / velocity), found by CORDIC vectoring, and is zero when the
// speed magnitude is below the threshold or the numerator is zero. A single
// add/subtract/shift datapath runs one CORDIC step per cycle and one shared
// multiplier serves the numerator and both moving averages. The step count
// is capped at 24, and the CORDIC steps are skipped when the angle is forced
// to zero. A stall on the output side holds the block. The block takes no
// new word while one is in work.
// ----------------------------------------------------------------------------
// steering_angle_from_yaw_rate_filter_top
// bicycle-model steering angle with exponential smoothing, apb register port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module steering_angle_from_yaw_rate_filter_top #(
  parameter int CORDIC_STEPS  = safyr_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = safyr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // apb register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [safyr_pkg::APB_AW-1:0]         paddr,
  input  logic [safyr_pkg::APB_DW-1:0]         pwdata,
  output logic [safyr_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready,
  // input words
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [safyr_pkg::DATA_W-1:0]  forward_velocity,
  input  logic signed [safyr_pkg::DATA_W-1:0]  yaw_rate,
  // output frames
  output logic                                 frame_valid,
  input  logic                                 frame_ready,
  output logic                                 frame_kind,
  output logic [safyr_pkg::ID_W-1:0]           frame_id,
  output logic signed [safyr_pkg::DATA_W-1:0]  payload_value,
  output logic                                 last
);

  import safyr_pkg::*;

  localparam int FB     = FRACTION_BITS;
  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int IW     = $clog2(NSTEPS);
  localparam int AGW    = FB + 2;
  localparam int GW     = (FB + 1 > GAIN_W) ? FB + 1 : GAIN_W;
  localparam int AW     = (AGW + 1 > DATA_W + 1) ? AGW + 1 : DATA_W + 1;
  localparam int BW     = ((GW > WHEELBASE_W) ? GW : WHEELBASE_W) + 1;
  localparam int PW     = AW + BW;
  localparam int XM     = DATA_W + FB + 1;
  localparam int YM     = DATA_W + WHEELBASE_W + 1;
  localparam int CW     = ((XM > YM) ? XM : YM) + 3;
  localparam int ZW     = 33;
  localparam int SH     = 30 - FB;

  localparam logic [GW-1:0]        GAIN_ONE = GW'(longint'(1) << FB);
  localparam logic signed [ZW:0]   Z_HALF   = (ZW + 1)'(longint'(1) << (SH - 1));
  localparam logic signed [PW-1:0] P_HALF   = PW'(longint'(1) << (FB - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NUM,
    S_PREP,
    S_ITER,
    S_ROUND,
    S_ANG_MUL,
    S_ANG_ADD,
    S_SPD_MUL,
    S_SPD_ADD,
    S_SEND
  } state_t;

  // configuration registers
  logic [WHEELBASE_W-1:0] wheelbase;
  logic [THRESH_W-1:0]    velocity_threshold;
  logic [GAIN_W-1:0]      angle_gain;
  logic [GAIN_W-1:0]      speed_gain;
  logic [ID_W-1:0]        speed_frame_id;
  logic [ID_W-1:0]        angle_frame_id;

  // sequencer and datapath registers
  state_t                  state;
  logic signed [DATA_W-1:0] vel;
  logic signed [DATA_W-1:0] yaw;
  logic signed [PW-1:0]    prod;
  logic signed [CW-1:0]    cx;
  logic signed [CW-1:0]    cy;
  logic signed [ZW-1:0]    cz;
  logic [IW-1:0]           step;
  logic signed [AGW-1:0]   raw_angle;
  logic signed [AGW-1:0]   smoothed_angle;
  logic signed [DATA_W-1:0] smoothed_speed;

  // combinational helpers
  logic [GW-1:0]           angle_gain_eff;
  logic [GW-1:0]           speed_gain_eff;
  logic signed [AGW:0]     ang_diff;
  logic signed [DATA_W:0]  spd_diff;
  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [DATA_W-1:0]       vel_u;
  logic [DATA_W-1:0]       speed_abs;
  logic signed [CW-1:0]    num;
  logic                    angle_zero;
  logic signed [CW-1:0]    xs;
  logic signed [CW-1:0]    ys;
  logic signed [ZW-1:0]    atan_step;
  logic signed [ZW:0]      z_round;
  logic signed [ZW:0]      z_shift;
  logic signed [PW-1:0]    e_round;
  logic signed [PW-1:0]    e_shift;
  logic signed [AGW-1:0]   ang_new;
  logic signed [DATA_W-1:0] spd_new;

  assign pready     = 1'b1;
  assign item_ready = (state == S_IDLE);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase          <= WHEELBASE_RST;
      velocity_threshold <= THRESH_RST;
      angle_gain         <= ANGLE_GAIN_RST;
      speed_gain         <= SPEED_GAIN_RST;
      speed_frame_id     <= SPEED_ID_RST;
      angle_frame_id     <= ANGLE_ID_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[APB_AW-1:2]))
        REG_WHEELBASE:  wheelbase          <= pwdata[WHEELBASE_W-1:0];
        REG_THRESHOLD:  velocity_threshold <= pwdata[THRESH_W-1:0];
        REG_ANGLE_GAIN: angle_gain         <= pwdata[GAIN_W-1:0];
        REG_SPEED_GAIN: speed_gain         <= pwdata[GAIN_W-1:0];
        REG_SPEED_ID:   speed_frame_id     <= pwdata[ID_W-1:0];
        REG_ANGLE_ID:   angle_frame_id     <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx_t'(paddr[APB_AW-1:2]))
      REG_WHEELBASE:  prdata = APB_DW'(wheelbase);
      REG_THRESHOLD:  prdata = APB_DW'(velocity_threshold);
      REG_ANGLE_GAIN: prdata = APB_DW'(angle_gain);
      REG_SPEED_GAIN: prdata = APB_DW'(speed_gain);
      REG_SPEED_ID:   prdata = APB_DW'(speed_frame_id);
      REG_ANGLE_ID:   prdata = APB_DW'(angle_frame_id);
      default:        prdata = '0;
    endcase
  end

  // gains above one act as exactly one
  assign angle_gain_eff = (GW'(angle_gain) > GAIN_ONE) ? GAIN_ONE : GW'(angle_gain);
  assign speed_gain_eff = (GW'(speed_gain) > GAIN_ONE) ? GAIN_ONE : GW'(speed_gain);

  // filter error terms
  assign ang_diff = (AGW + 1)'(raw_angle) - (AGW + 1)'(smoothed_angle);
  assign spd_diff = (DATA_W + 1)'(vel) - (DATA_W + 1)'(smoothed_speed);

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL_NUM: begin
        mul_a = AW'(yaw);
        mul_b = BW'(wheelbase);
      end
      S_ANG_MUL: begin
        mul_a = AW'(ang_diff);
        mul_b = BW'(angle_gain_eff);
      end
      S_SPD_MUL: begin
        mul_a = AW'(spd_diff);
        mul_b = BW'(speed_gain_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // speed magnitude, signed numerator and the zero-angle test
  assign vel_u      = vel;
  assign speed_abs  = vel_u[DATA_W-1] ? (~vel_u + DATA_W'(1)) : vel_u;
  assign num        = vel[DATA_W-1] ? -CW'(prod) : CW'(prod);
  assign angle_zero = (speed_abs < DATA_W'(velocity_threshold)) || (num == '0);

  // one cordic vectoring step
  assign xs        = cx >>> step;
  assign ys        = cy >>> step;
  assign atan_step = ZW'(atan_q30(ATAN_IW'(step)));

  // round the q30 angle to the output fraction
  assign z_round = (ZW + 1)'(cz) + Z_HALF;
  assign z_shift = z_round >>> SH;

  // filter update: s + round(gain * err)
  assign e_round = prod + P_HALF;
  assign e_shift = e_round >>> FB;
  assign ang_new = smoothed_angle + e_shift[AGW-1:0];
  assign spd_new = smoothed_speed + e_shift[DATA_W-1:0];

  // sequencer, datapath and output frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      frame_valid    <= 1'b0;
      smoothed_angle <= '0;
      smoothed_speed <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            vel   <= forward_velocity;
            yaw   <= yaw_rate;
            state <= S_MUL_NUM;
          end
        end
        S_MUL_NUM: begin
          prod  <= mul_p;
          state <= S_PREP;
        end
        S_PREP: begin
          cx   <= CW'({speed_abs, {FB{1'b0}}});
          cy   <= num;
          cz   <= '0;
          step <= '0;
          if (angle_zero) begin
            raw_angle <= '0;
            state     <= S_ANG_MUL;
          end else begin
            state <= S_ITER;
          end
        end
        S_ITER: begin
          if (!cy[CW-1]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_step;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_step;
          end
          if (step == IW'(NSTEPS - 1)) begin
            state <= S_ROUND;
          end else begin
            step <= step + IW'(1);
          end
        end
        S_ROUND: begin
          raw_angle <= z_shift[AGW-1:0];
          state     <= S_ANG_MUL;
        end
        S_ANG_MUL: begin
          prod  <= mul_p;
          state <= S_ANG_ADD;
        end
        S_ANG_ADD: begin
          smoothed_angle <= ang_new;
          state          <= S_SPD_MUL;
        end
        S_SPD_MUL: begin
          prod  <= mul_p;
          state <= S_SPD_ADD;
        end
        S_SPD_ADD: begin
          smoothed_speed <= spd_new;
          frame_valid    <= 1'b1;
          frame_kind     <= KIND_SPEED;
          frame_id       <= speed_frame_id;
          payload_value  <= sat_data(SAT_W'(spd_new));
          last           <= 1'b0;
          state          <= S_SEND;
        end
        S_SEND: begin
          if (frame_ready) begin
            if (!last) begin
              frame_kind    <= KIND_ANGLE;
              frame_id      <= angle_frame_id;
              payload_value <= sat_data(SAT_W'(smoothed_angle));
              last          <= 1'b1;
            end else begin
              frame_valid <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/safyr_checker.sv @@
// ----------------------------------------------------------------------------
// safyr_checker
// port-level checks on frame pairing and busy behavior of the steering filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "steering_angle_from_yaw_rate_filter_top_defines.svh"

module safyr_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        frame_valid,
  input logic        frame_ready,
  input logic        frame_kind,
  input logic        last,
  input logic [23:0] payload_value
);

  // no new word is taken while frames are pending
  `SAFYR_ASSERT_NOW(a_busy_while_sending, frame_valid, !item_ready)

  // an accepted word starts work and blocks the input side
  `SAFYR_ASSERT_NEXT(a_accept_busy, item_valid && item_ready, !item_ready && !frame_valid)

  // the speed word is followed at once by the angle word
  `SAFYR_ASSERT_NEXT(a_pair_second, frame_valid && frame_ready && !last,
                     frame_valid && last && frame_kind)

  // a stalled word holds its payload
  `SAFYR_ASSERT_NEXT(a_hold_stalled, frame_valid && !frame_ready,
                     frame_valid && $stable(payload_value) && $stable(last))

endmodule

bind steering_angle_from_yaw_rate_filter_top safyr_checker u_safyr_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_ready    (item_ready),
  .frame_valid   (frame_valid),
  .frame_ready   (frame_ready),
  .frame_kind    (frame_kind),
  .last          (last),
  .payload_value (payload_value)
);
